// File: hw/rtl/mce_pkg.sv
package mce_pkg;

    localparam int OPCODE_W          = 2;
    localparam int NODE_W            = 6;
    localparam int WEIGHT_W          = 16;
    localparam int LABEL_W           = 8;
    localparam int CUT_W             = 27;
    localparam int NCOUNT_W          = 7;
    localparam int MAX_NODES_DEFAULT = 64;

    localparam logic [NCOUNT_W-1:0] NODE_COUNT_RESET = 7'd64;

    localparam logic [OPCODE_W-1:0] OP_EDGE  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LABEL = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EVAL  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROW,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clr_step;
        logic in_ready;
        logic eval_start;
        logic row_load;
        logic scan;
        logic next_row;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic eval_req;
        logic n_lt2;
        logic col_last;
        logic row_last;
        logic out_free;
    } status_t;

endpackage

// File: hw/rtl/mce_in_if.sv
interface mce_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [mce_pkg::OPCODE_W-1:0]         opcode;
    logic [mce_pkg::NODE_W-1:0]           node_a;
    logic [mce_pkg::NODE_W-1:0]           node_b;
    logic signed [mce_pkg::WEIGHT_W-1:0]  weight;
    logic [mce_pkg::LABEL_W-1:0]          label;

    modport source (output valid, opcode, node_a, node_b, weight, label, input ready);
    modport sink   (input valid, opcode, node_a, node_b, weight, label, output ready);
endinterface

// File: hw/rtl/mce_out_if.sv
interface mce_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [mce_pkg::CUT_W-1:0]  cut_value;

    modport source (output valid, cut_value, input ready);
    modport sink   (input valid, cut_value, output ready);
endinterface

// File: hw/rtl/mce_ctrl.sv
module mce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  mce_pkg::status_t  status,
    output mce_pkg::cmd_t     cmd
);

    mce_pkg::state_t state_reg;
    mce_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mce_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            mce_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_done)
                begin
                    state_next = mce_pkg::ST_IDLE;
                end
            end
            mce_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.eval_req)
                begin
                    cmd.eval_start = 1'b1;
                    state_next     = status.n_lt2 ? mce_pkg::ST_DONE : mce_pkg::ST_ROW;
                end
            end
            mce_pkg::ST_ROW:
            begin
                cmd.row_load = 1'b1;
                state_next   = mce_pkg::ST_SCAN;
            end
            mce_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.col_last)
                begin
                    if (status.row_last)
                    begin
                        state_next = mce_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        cmd.next_row = 1'b1;
                        state_next   = mce_pkg::ST_ROW;
                    end
                end
            end
            mce_pkg::ST_DRAIN:
            begin
                state_next = mce_pkg::ST_DONE;
            end
            mce_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = mce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mce_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/mce_datapath.sv
module mce_datapath #(
    parameter int MAX_NODES = mce_pkg::MAX_NODES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            node_count_we,
    input  logic [mce_pkg::NCOUNT_W-1:0]    node_count_wdata,
    mce_in_if.sink                          in_ch,
    mce_out_if.source                       out_ch,
    input  mce_pkg::cmd_t                   cmd,
    output mce_pkg::status_t                status
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int DEPTH  = 2 ** ADDR_W;

    logic signed [mce_pkg::WEIGHT_W-1:0] weight_mem [DEPTH];
    logic [mce_pkg::LABEL_W-1:0]         label_mem [MAX_NODES];

    logic [mce_pkg::NCOUNT_W-1:0]        node_count_reg;
    logic [mce_pkg::NCOUNT_W-1:0]        n_act;
    logic [ADDR_W-1:0]                   clr_addr_reg;
    logic [IDX_W-1:0]                    row_reg;
    logic [IDX_W-1:0]                    col_reg;
    logic                                p_vld_reg;
    logic                                row_cap_reg;
    logic [mce_pkg::LABEL_W-1:0]         row_label_reg;
    logic [mce_pkg::LABEL_W-1:0]         label_rd_reg;
    logic signed [mce_pkg::WEIGHT_W-1:0] weight_rd_reg;
    logic signed [mce_pkg::CUT_W-1:0]    acc_reg;
    logic signed [mce_pkg::CUT_W-1:0]    cut_reg;
    logic                                out_valid_reg;

    logic                                accept;
    logic                                a_ok;
    logic                                b_ok;
    logic                                edge_we;
    logic                                label_we;
    logic [IDX_W-1:0]                    idx_a;
    logic [IDX_W-1:0]                    idx_b;
    logic [IDX_W-1:0]                    label_raddr;

    assign accept   = in_ch.valid && in_ch.ready;
    assign a_ok     = 32'(in_ch.node_a) < MAX_NODES;
    assign b_ok     = 32'(in_ch.node_b) < MAX_NODES;
    assign idx_a    = IDX_W'(in_ch.node_a);
    assign idx_b    = IDX_W'(in_ch.node_b);
    assign edge_we  = accept && (in_ch.opcode == mce_pkg::OP_EDGE) && a_ok && b_ok;
    assign label_we = accept && (in_ch.opcode == mce_pkg::OP_LABEL) && a_ok;

    assign n_act = (32'(node_count_reg) > MAX_NODES) ? mce_pkg::NCOUNT_W'(MAX_NODES)
                                                     : node_count_reg;

    assign label_raddr = cmd.row_load ? row_reg : col_reg;

    assign in_ch.ready      = cmd.in_ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.cut_value = cut_reg;

    assign status.clr_done = (clr_addr_reg == {ADDR_W{1'b1}});
    assign status.eval_req = in_ch.valid && (in_ch.opcode == mce_pkg::OP_EVAL);
    assign status.n_lt2    = n_act < mce_pkg::NCOUNT_W'(2);
    assign status.col_last = (32'(col_reg) + 32'd1) == 32'(n_act);
    assign status.row_last = (32'(row_reg) + 32'd2) == 32'(n_act);
    assign status.out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            weight_mem[clr_addr_reg] <= '0;
        end
        else if (edge_we)
        begin
            weight_mem[{idx_a, idx_b}] <= in_ch.weight;
        end
        weight_rd_reg <= weight_mem[{row_reg, col_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (label_we)
        begin
            label_mem[idx_a] <= in_ch.label;
        end
        label_rd_reg <= label_mem[label_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= mce_pkg::NODE_COUNT_RESET;
            clr_addr_reg   <= '0;
            row_reg        <= '0;
            col_reg        <= '0;
            p_vld_reg      <= 1'b0;
            row_cap_reg    <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (node_count_we)
            begin
                node_count_reg <= node_count_wdata;
            end
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end

            p_vld_reg   <= cmd.scan;
            row_cap_reg <= cmd.row_load;

            if (cmd.eval_start)
            begin
                row_reg <= '0;
                col_reg <= IDX_W'(1);
            end
            else if (cmd.next_row)
            begin
                row_reg <= row_reg + IDX_W'(1);
                col_reg <= row_reg + IDX_W'(2);
            end
            else if (cmd.scan && !status.col_last)
            begin
                col_reg <= col_reg + IDX_W'(1);
            end

            if (cmd.eval_start)
            begin
                acc_reg <= '0;
            end
            else if (p_vld_reg && (label_rd_reg != row_label_reg))
            begin
                acc_reg <= acc_reg + mce_pkg::CUT_W'(weight_rd_reg);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_cap_reg)
        begin
            row_label_reg <= label_rd_reg;
        end
        if (cmd.emit)
        begin
            cut_reg <= acc_reg;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (col_reg > row_reg))
        else $error("scan column not above row");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (32'(col_reg) < 32'(n_act)))
        else $error("scan column beyond active nodes");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("result not presented after emit");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(p_vld_reg || row_cap_reg))
        else $error("result emitted while accumulation in flight");

endmodule

// File: hw/rtl/max_cut_evaluator.sv
// Channel     Direction  Handshake     Payload
// in_ch       in         valid/ready   opcode, node_a, node_b, weight, label
// out_ch      out        valid/ready   cut_value
// node_count  in         we/wdata      node_count_wdata (7 bits)
//
// Edge and label write transactions are accepted while the controller is idle.
// An evaluate transaction scans every pair of the n active nodes (none for n < 2) through the
// single read port of the weight memory, one pair per cycle while scanning.
// After reset all 2**(2*clog2(MAX_NODES)) weight memory entries (4096 by default) are zeroed,
// with in_ch.ready low. A stalled result waits in the output register while writes continue.
module max_cut_evaluator #(
    parameter int MAX_NODES = mce_pkg::MAX_NODES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          node_count_we,
    input  logic [mce_pkg::NCOUNT_W-1:0]  node_count_wdata,
    mce_in_if.sink                        in_ch,
    mce_out_if.source                     out_ch
);

    mce_pkg::cmd_t    cmd;
    mce_pkg::status_t status;

    mce_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    mce_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .node_count_we    (node_count_we),
        .node_count_wdata (node_count_wdata),
        .in_ch            (in_ch),
        .out_ch           (out_ch),
        .cmd              (cmd),
        .status           (status)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mce_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int NODES        = MAX_NODES_DEFAULT;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [OPCODE_W-1:0]        opcode;
        logic [NODE_W-1:0]          node_a;
        logic [NODE_W-1:0]          node_b;
        logic signed [WEIGHT_W-1:0] weight;
        logic [LABEL_W-1:0]         label;
    } cut_req_t;

    logic                clk;
    logic                rst_n;
    logic                node_count_we;
    logic [NCOUNT_W-1:0] node_count_wdata;

    mce_in_if  in_if ();
    mce_out_if out_if ();

    max_cut_evaluator u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .node_count_we    (node_count_we),
        .node_count_wdata (node_count_wdata),
        .in_ch            (in_if),
        .out_ch           (out_if)
    );

    logic signed [WEIGHT_W-1:0] edge_w [NODES][NODES];
    logic [LABEL_W-1:0]         part_label [NODES];
    logic [NCOUNT_W-1:0]        node_cnt_cfg;
    bit [NODES-1:0]             label_set;

    cut_req_t                req_pending [$];
    cut_req_t                next_req;
    logic signed [CUT_W-1:0] cut_expected [$];
    logic signed [CUT_W-1:0] exp_cut;

    bit      idle_en;
    int      gap_left;
    int      stall_left;
    int      items_made;
    int      mismatches;
    longint  cycle_cnt;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int active_nodes();
        int n;
        n = node_cnt_cfg;
        return (n > NODES) ? NODES : n;
    endfunction

    function automatic logic signed [CUT_W-1:0] cut_of_partition();
        longint acc;
        int     n;
        n   = active_nodes();
        acc = 0;
        for (int r = 0; r < n; r++)
        begin
            for (int c = r + 1; c < n; c++)
            begin
                if (part_label[r] != part_label[c])
                    acc += edge_w[r][c];
            end
        end
        return acc[CUT_W-1:0];
    endfunction

    function automatic logic [WEIGHT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            default: return WEIGHT_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [LABEL_W-1:0] rand_label();
        if ($urandom_range(0, 3) != 0)
            return LABEL_W'($urandom_range(0, 2));
        return LABEL_W'($urandom_range(0, 255));
    endfunction

    task automatic report_mismatch(input string what, input logic signed [CUT_W-1:0] got,
                                   input logic signed [CUT_W-1:0] want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic push_req(input logic [OPCODE_W-1:0] op, input int a, input int b,
                            input logic [WEIGHT_W-1:0] w, input logic [LABEL_W-1:0] l);
        cut_req_t req;
        req.opcode = op;
        req.node_a = NODE_W'(a);
        req.node_b = NODE_W'(b);
        req.weight = w;
        req.label  = l;
        req_pending.push_back(req);
        if (op == OP_LABEL)
            label_set[req.node_a] = 1'b1;
        if (op != OP_UNUSED)
            items_made++;
    endtask

    // label every active node first so no unwritten label is read
    task automatic push_eval();
        for (int i = 0; i < active_nodes(); i++)
        begin
            if (!label_set[i])
                push_req(OP_LABEL, i, $urandom_range(0, 63), rand_weight(), rand_label());
        end
        push_req(OP_EVAL, $urandom_range(0, 63), $urandom_range(0, 63), rand_weight(),
                 LABEL_W'($urandom_range(0, 255)));
    endtask

    task automatic write_node_count(input logic [NCOUNT_W-1:0] v);
        @(posedge clk);
        node_count_we    <= 1'b1;
        node_count_wdata <= v;
        @(posedge clk);
        node_count_we    <= 1'b0;
        node_cnt_cfg      = v;
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (req_pending.size() != 0 || in_if.valid || cut_expected.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int n_items);
        int start;
        int span;
        int a;
        int b;
        int t;
        start = items_made;
        span  = (active_nodes() < 2) ? NODES : active_nodes();
        while (items_made - start < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        a = $urandom_range(0, span - 1);
                        b = $urandom_range(0, span - 1);
                        if (a > b && $urandom_range(0, 7) != 0)
                        begin
                            t = a;
                            a = b;
                            b = t;
                        end
                        push_req(OP_EDGE, a, b, rand_weight(), LABEL_W'($urandom_range(0, 255)));
                    end
                    repeat ($urandom_range(1, 4))
                        push_req(OP_LABEL, $urandom_range(0, span - 1), $urandom_range(0, 63),
                                 rand_weight(), rand_label());
                    push_eval();
                end
                7:
                begin
                    if ($urandom_range(0, 1))
                        push_req(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                                 rand_weight(), LABEL_W'($urandom_range(0, 255)));
                    else
                        push_req(OP_EDGE, $urandom_range(0, 63), $urandom_range(0, 63),
                                 rand_weight(), LABEL_W'($urandom_range(0, 255)));
                end
                8:
                    push_eval();
                default:
                    repeat ($urandom_range(1, 4))
                        push_req(OP_LABEL, $urandom_range(0, 63), $urandom_range(0, 63),
                                 rand_weight(), rand_label());
            endcase
        end
    endtask

    // driver: hold valid until the transaction completes, advance the model on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_if.valid <= 1'b0;
            gap_left    <= 0;
        end
        else
        begin
            if (in_if.valid && in_if.ready)
            begin
                case (in_if.opcode)
                    OP_EDGE:  edge_w[in_if.node_a][in_if.node_b] = in_if.weight;
                    OP_LABEL: part_label[in_if.node_a] = in_if.label;
                    OP_EVAL:  cut_expected.push_back(cut_of_partition());
                    default:  ;
                endcase
            end
            if (!in_if.valid || in_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left    <= gap_left - 1;
                    in_if.valid <= 1'b0;
                end
                else if (idle_en && $urandom_range(0, 7) == 0)
                begin
                    gap_left    <= $urandom_range(0, 4);
                    in_if.valid <= 1'b0;
                end
                else if (req_pending.size() != 0)
                begin
                    next_req      = req_pending.pop_front();
                    in_if.opcode <= next_req.opcode;
                    in_if.node_a <= next_req.node_a;
                    in_if.node_b <= next_req.node_b;
                    in_if.weight <= next_req.weight;
                    in_if.label  <= next_req.label;
                    in_if.valid  <= 1'b1;
                end
                else
                    in_if.valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result with the oldest pending evaluation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_if.ready <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            if (out_if.valid && out_if.ready)
            begin
                if (cut_expected.size() == 0)
                    report_mismatch("cut_value with no evaluate pending", out_if.cut_value, '0);
                else
                begin
                    exp_cut = cut_expected.pop_front();
                    if (out_if.cut_value !== exp_cut)
                        report_mismatch("cut_value", out_if.cut_value, exp_cut);
                end
            end
            if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                out_if.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                stall_left   <= $urandom_range(0, 4);
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        node_count_we    = 1'b0;
        node_count_wdata = '0;
        in_if.valid      = 1'b0;
        in_if.opcode     = '0;
        in_if.node_a     = '0;
        in_if.node_b     = '0;
        in_if.weight     = '0;
        in_if.label      = '0;
        out_if.ready     = 1'b0;
        idle_en          = 1'b1;
        cycle_cnt        = 0;
        mismatches       = 0;
        items_made       = 0;
        label_set        = '0;
        node_cnt_cfg     = NODE_COUNT_RESET;
        for (int r = 0; r < NODES; r++)
        begin
            part_label[r] = '0;
            for (int c = 0; c < NODES; c++)
                edge_w[r][c] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset node count, cleared weights, extreme weights and labels
        for (int i = 0; i < NODES; i++)
            push_req(OP_LABEL, i, 63 - i, 16'h0000, (i % 2) ? 8'hFF : 8'h00);
        push_eval();
        push_req(OP_EDGE, 0, 1, 16'h8000, 8'h00);
        push_req(OP_EDGE, 0, 63, 16'h7FFF, 8'hFF);
        push_req(OP_EDGE, 62, 63, 16'hFFFF, 8'h00);
        push_req(OP_EDGE, 1, 62, 16'h7FFF, 8'h00);
        push_req(OP_EDGE, 63, 0, 16'h1234, 8'h00);
        push_req(OP_EDGE, 7, 7, 16'h0032, 8'h00);
        push_req(OP_UNUSED, 63, 63, 16'hFFFF, 8'hFF);
        push_eval();
        push_req(OP_LABEL, 1, 0, 16'h0000, 8'h00);
        push_req(OP_LABEL, 62, 0, 16'h0000, 8'hFF);
        push_eval();
        wait_drained();

        // empty sums and clamped node counts
        write_node_count(7'd0);
        push_eval();
        push_req(OP_EDGE, 0, 1, 16'h4000, 8'h00);
        push_eval();
        wait_drained();
        write_node_count(7'd1);
        push_eval();
        wait_drained();
        write_node_count(7'd127);
        push_eval();
        wait_drained();
        write_node_count(7'd65);
        push_eval();
        wait_drained();
        write_node_count(7'd2);
        push_req(OP_LABEL, 0, 0, 16'h0000, 8'h05);
        push_req(OP_LABEL, 1, 0, 16'h0000, 8'hFA);
        push_req(OP_EDGE, 0, 1, 16'h7FFF, 8'h00);
        push_eval();
        random_phase(40);

        for (int p = 0; p < 7; p++)
        begin
            wait_drained();
            write_node_count((p == 3) ? 7'd64 : NCOUNT_W'($urandom_range(2, 12)));
            idle_en = (p != 5);
            random_phase((p == 3) ? 40 : 50);
        end

        wait_drained();
        write_node_count(NCOUNT_W'($urandom_range(2, 16)));
        idle_en = 1'b0;
        random_phase(70);
        wait_drained();

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mce_pkg.sv
hw/rtl/mce_in_if.sv
hw/rtl/mce_out_if.sv
hw/rtl/mce_ctrl.sv
hw/rtl/mce_datapath.sv
hw/rtl/max_cut_evaluator.sv
verif/tb_top.sv
